// File: rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants for the searchable deque store: operation and
// status codes, sequencer states and the per-cell control word.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // Default sizing
  localparam int unsigned CapacityDefault  = 16;
  localparam int unsigned ValueBitsDefault = 32;

  // Port field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned InValW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OutValW = 32;
  localparam int unsigned CountW  = 5;

  // Operation codes (six and seven behave as count)
  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_FIND       = 3'd3,
    OP_DELETE     = 3'd4,
    OP_COUNT      = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Per-cell control word
  typedef struct packed {
    logic compare;     // register the match against the incoming key
    logic load_new;    // take the new value
    logic take_left;   // take the value of the cell nearer the front
    logic take_right;  // take the value of the cell nearer the back
  } cell_ctrl_t;

endpackage

// File: rtl/sdq_cell.sv
// ----------------------------------------------------------------------------
// sdq_cell
// One storage cell of the deque chain. Holds one entry, registers whether it
// matches the search key, and shifts toward either neighbor on command.
// ----------------------------------------------------------------------------
module sdq_cell #(
  parameter int unsigned VALUE_BITS = sdq_pkg::ValueBitsDefault
) (
  input  logic                   clk_i,
  input  sdq_pkg::cell_ctrl_t    ctrl_i,
  input  logic [VALUE_BITS-1:0]  key_i,
  input  logic [VALUE_BITS-1:0]  new_value_i,
  input  logic [VALUE_BITS-1:0]  left_value_i,
  input  logic [VALUE_BITS-1:0]  right_value_i,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   hit_o
);
  import sdq_pkg::*;

  logic [VALUE_BITS-1:0] value_q;
  logic                  hit_q;

  // Load, shift or hold the entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_new) begin
      value_q <= new_value_i;
    end else if (ctrl_i.take_left) begin
      value_q <= left_value_i;
    end else if (ctrl_i.take_right) begin
      value_q <= right_value_i;
    end
  end

  // Capture the match against the key of the incoming beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.compare) begin
      hit_q <= (value_q == key_i);
    end
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// File: rtl/searchable_deque_store_top.sv
// Flow: an accepted beat moves into the execute state, and its result is registered
// there once no earlier result is still held off by the result side.
// One item at a time: no new beat is taken until the current one leaves execute; the cells
// compare on accept and the priority pick plus shift of the whole cell row is done in execute.
// A result waiting in the output register does not block the next accept.
// Reset clears the entry count and all handshake state; cell contents are
// left as they are and never read above the count.
// ----------------------------------------------------------------------------
// searchable_deque_store_top
// Ordered store built as a row of cells: push at either end, pop the front,
// find or delete the first matching entry, and report the count.
// ----------------------------------------------------------------------------
module searchable_deque_store_top #(
  parameter int unsigned CAPACITY   = sdq_pkg::CapacityDefault,
  parameter int unsigned VALUE_BITS = sdq_pkg::ValueBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sdq_pkg::OpW-1:0]           op_i,
  input  logic signed [sdq_pkg::InValW-1:0] value_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sdq_pkg::StatusW-1:0]       status_o,
  output logic                              found_o,
  output logic [sdq_pkg::PosW-1:0]          position_o,
  output logic signed [sdq_pkg::OutValW-1:0] front_value_o,
  output logic [sdq_pkg::CountW-1:0]        count_o
);
  import sdq_pkg::*;

  localparam int unsigned CntBits = $clog2(CAPACITY + 1);
  localparam int unsigned IdxBits = $clog2(CAPACITY);

  state_e                state_q, state_d;
  op_e                   op_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [VALUE_BITS-1:0] key_in;
  logic [CntBits-1:0]    count_q, count_d;

  logic                  in_accept;
  logic                  fire;

  cell_ctrl_t            ctrl [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   cell_hit;
  logic [CAPACITY-1:0]   occ;
  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   first_oh;
  logic [CAPACITY-1:0]   after_mask;
  logic [IdxBits-1:0]    pos;
  logic                  any_hit;
  logic                  full;
  logic                  empty;

  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic                  found_q, found_d;
  logic [PosW-1:0]       position_q, position_d;
  logic [OutValW-1:0]    front_q, front_d;
  logic [CountW-1:0]     count_out_q;

  // Handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign fire       = (state_q == S_EXEC) & ~(out_valid_q & out_stall_i);

  // Sign-extend or cut the incoming value to the entry width
  assign key_in = VALUE_BITS'(value_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= fire | (out_valid_q & out_stall_i);
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(op_i);
      key_q <= key_in;
    end
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = key_q;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    sdq_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl[i]),
      .key_i         (key_in),
      .new_value_i   (key_q),
      .left_value_i  (left_val),
      .right_value_i (right_val),
      .value_o       (cell_val[i]),
      .hit_o         (cell_hit[i])
    );

    assign occ[i] = (CntBits'(i) < count_q);
  end

  // Pick the first match: isolate the lowest set hit bit
  assign hit_vec    = cell_hit & occ;
  assign first_oh   = hit_vec & (~hit_vec + CAPACITY'(1));
  assign after_mask = ~(first_oh - CAPACITY'(1));
  assign any_hit    = |hit_vec;
  assign full       = (count_q == CntBits'(CAPACITY));
  assign empty      = (count_q == '0);

  // Encode the match position
  always_comb begin
    pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) begin
        pos = pos | IdxBits'(i);
      end
    end
  end

  // Decode the operation into cell commands, new count and result
  always_comb begin
    count_d    = count_q;
    status_d   = ST_DONE;
    found_d    = 1'b0;
    position_d = '0;
    front_d    = empty ? '0 : OutValW'(cell_val[0]);
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      ctrl[i]         = '0;
      ctrl[i].compare = in_accept;
    end
    if (fire) begin
      case (op_q)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CntBits'(1);
            for (int unsigned i = 0; i < CAPACITY; i++) begin
              ctrl[i].load_new = (CntBits'(i) == count_q);
            end
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CntBits'(1);
            for (int unsigned i = 0; i < CAPACITY; i++) begin
              ctrl[i].load_new  = (i == 0);
              ctrl[i].take_left = (i != 0);
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_MISS;
          end else begin
            count_d = count_q - CntBits'(1);
            for (int unsigned i = 0; i < CAPACITY; i++) begin
              ctrl[i].take_right = 1'b1;
            end
          end
        end
        OP_FIND: begin
          if (any_hit) begin
            found_d    = 1'b1;
            position_d = PosW'(pos);
          end else begin
            status_d = ST_MISS;
          end
        end
        OP_DELETE: begin
          if (any_hit) begin
            found_d    = 1'b1;
            position_d = PosW'(pos);
            count_d    = count_q - CntBits'(1);
            for (int unsigned i = 0; i < CAPACITY; i++) begin
              ctrl[i].take_right = after_mask[i];
            end
          end else begin
            status_d = ST_MISS;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q    <= status_d;
      found_q     <= found_d;
      position_q  <= position_d;
      front_q     <= front_d;
      count_out_q <= CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign position_o    = position_q;
  assign front_value_o = front_q;
  assign count_o       = count_out_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted beat did not enter execute");

  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> $onehot0(first_oh))
    else $error("first match pick not one-hot");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && found_d) |-> (status_d == ST_DONE))
    else $error("match reported with non-done status");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("count changed outside execute");
`endif

endmodule
